/* rtl/hsv_to_rgb_converter_unit_macros.svh */
// ----------------------------------------------------------------------------
// HSV to RGB converter assertion macros
// Concurrent checks sampled on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef HSV_TO_RGB_CONVERTER_UNIT_MACROS_SVH
`define HSV_TO_RGB_CONVERTER_UNIT_MACROS_SVH

// Same-cycle implication.
`define HSV_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define HSV_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/hsv2rgb_pkg.sv */
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// Request and response types and fixed-point constants of the HSV to RGB
// converter.
// ----------------------------------------------------------------------------
`default_nettype none

package hsv2rgb_pkg;

    typedef struct packed {
        logic [14:0] hue;
        logic [8:0]  saturation;
        logic [8:0]  brightness;
    } t_hsv_req;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb_rsp;

    typedef logic [2:0] t_sector;

    localparam logic [14:0] HUE_FULL   = 15'd23040;   // 360 degrees
    localparam logic [14:0] HUE_SECTOR = 15'd3840;    // 60 degrees
    localparam int          NUM_STAGES = 5;

    // rem / 15 == (rem * F_RECIP) >> F_SHIFT for rem in 0..3840
    localparam logic [15:0] F_RECIP = 16'd34953;
    localparam int          F_SHIFT = 19;

    localparam t_sector SEC_0 = 3'd0;
    localparam t_sector SEC_1 = 3'd1;
    localparam t_sector SEC_2 = 3'd2;
    localparam t_sector SEC_3 = 3'd3;
    localparam t_sector SEC_4 = 3'd4;
    localparam t_sector SEC_5 = 3'd5;

    function automatic logic [14:0] sector_base(input t_sector sec);
        logic [14:0] base;
        case (sec)
            SEC_0:   base = 15'd0;
            SEC_1:   base = HUE_SECTOR;
            SEC_2:   base = 15'(2 * HUE_SECTOR);
            SEC_3:   base = 15'(3 * HUE_SECTOR);
            SEC_4:   base = 15'(4 * HUE_SECTOR);
            default: base = 15'(5 * HUE_SECTOR);
        endcase
        return base;
    endfunction

endpackage

`default_nettype wire

/* rtl/hsv_to_rgb_converter_unit.sv */
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_unit
// Five-stage pipelined HSV to RGB conversion with 8-bit clamped channels.
// ----------------------------------------------------------------------------
// Takes one request per clock and returns one RGB response per request, in
// order; o_valid is the valid bit of the last stage register. Hue is degrees
// with 6 fraction bits (values above 360 act as 360); saturation and
// brightness are Q1.8. Stages: sector and remainder, fraction by reciprocal
// multiply, p/q/t factors, brightness multiply and channel select, scale by
// 255 and clamp into the output register. Each stage holds while the stage
// after it is full and stalled, so bubbles collapse and o_ready only drops
// when all five stages hold requests and i_ready is low.
`default_nettype none

module hsv_to_rgb_converter_unit
    import hsv2rgb_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_ready,
    input  wire t_hsv_req i_req,
    output logic          o_valid,
    input  wire logic     i_ready,
    output t_rgb_rsp      o_rsp
);

`include "hsv_to_rgb_converter_unit_macros.svh"

    function automatic logic [7:0] chan8(input logic signed [28:0] x);
        logic [24:0] xu;
        logic [32:0] prod;
        logic [8:0]  hi;
        logic [7:0]  res;
        xu   = x[24:0];
        prod = {xu, 8'b0} - {8'b0, xu};
        hi   = prod[32:24];
        if (x <= 29'sd0) begin
            res = 8'd0;
        end else if (hi > 9'd255) begin
            res = 8'hFF;
        end else begin
            res = hi[7:0];
        end
        return res;
    endfunction

    logic [NUM_STAGES-1:0] r_vld;
    logic [NUM_STAGES-1:0] en;

    // stage 0: sector and remainder
    t_sector     r_sec0;
    logic [11:0] r_rem0;
    logic [8:0]  r_s0, r_v0;
    // stage 1: fraction
    t_sector     r_sec1;
    logic [8:0]  r_f1, r_s1, r_v1;
    // stage 2: factors
    t_sector            r_sec2;
    logic [8:0]         r_v2;
    logic signed [18:0] r_aq2, r_at2;
    logic signed [9:0]  r_ap2;
    // stage 3: selected channel values, scaled by 2^24
    logic signed [28:0] r_r3, r_g3, r_b3;
    // stage 4: output
    t_rgb_rsp r_rsp;

    always_comb begin
        en[NUM_STAGES-1] = !r_vld[NUM_STAGES-1] || i_ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_vld[NUM_STAGES-1];
    assign o_rsp   = r_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // stage 0 logic
    logic [14:0] n_h;
    t_sector     n_sec0;
    logic [14:0] n_rem_full;
    always_comb begin
        n_h = (i_req.hue > HUE_FULL) ? HUE_FULL : i_req.hue;
        if (n_h >= 15'(5 * HUE_SECTOR)) begin
            n_sec0 = SEC_5;
        end else if (n_h >= 15'(4 * HUE_SECTOR)) begin
            n_sec0 = SEC_4;
        end else if (n_h >= 15'(3 * HUE_SECTOR)) begin
            n_sec0 = SEC_3;
        end else if (n_h >= 15'(2 * HUE_SECTOR)) begin
            n_sec0 = SEC_2;
        end else if (n_h >= HUE_SECTOR) begin
            n_sec0 = SEC_1;
        end else begin
            n_sec0 = SEC_0;
        end
        n_rem_full = n_h - sector_base(n_sec0);
    end

    // stage 1 logic
    logic [27:0] n_fprod;
    assign n_fprod = r_rem0 * F_RECIP;

    // stage 2 logic
    logic [17:0]        n_fs, n_gs;
    logic [8:0]         n_fc;
    logic signed [18:0] n_aq, n_at;
    logic signed [9:0]  n_ap;
    always_comb begin
        n_fc = 9'd256 - r_f1;
        n_fs = r_f1 * r_s1;
        n_gs = n_fc * r_s1;
        n_aq = 19'sd65536 - $signed({1'b0, n_fs});
        n_at = 19'sd65536 - $signed({1'b0, n_gs});
        n_ap = 10'sd256 - $signed({1'b0, r_s1});
    end

    // stage 3 logic
    logic signed [9:0]  n_vs;
    logic signed [28:0] n_q, n_t, n_p, n_cv;
    logic signed [19:0] n_pp;
    logic signed [28:0] n_r, n_g, n_b;
    always_comb begin
        n_vs = $signed({1'b0, r_v2});
        // widen both operands so the product keeps its full range
        n_q  = 29'(n_vs) * 29'(r_aq2);
        n_t  = 29'(n_vs) * 29'(r_at2);
        n_pp = n_vs * r_ap2;
        n_p  = 29'(n_pp) <<< 8;
        n_cv = $signed({4'b0, r_v2, 16'b0});
        case (r_sec2)
            SEC_0:   begin n_r = n_cv; n_g = n_t;  n_b = n_p;  end
            SEC_1:   begin n_r = n_q;  n_g = n_cv; n_b = n_p;  end
            SEC_2:   begin n_r = n_p;  n_g = n_cv; n_b = n_t;  end
            SEC_3:   begin n_r = n_p;  n_g = n_q;  n_b = n_cv; end
            SEC_4:   begin n_r = n_t;  n_g = n_p;  n_b = n_cv; end
            default: begin n_r = n_cv; n_g = n_p;  n_b = n_q;  end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_sec0 <= n_sec0;
            r_rem0 <= n_rem_full[11:0];
            r_s0   <= i_req.saturation;
            r_v0   <= i_req.brightness;
        end
        if (en[1]) begin
            r_sec1 <= r_sec0;
            r_f1   <= n_fprod[27:F_SHIFT];
            r_s1   <= r_s0;
            r_v1   <= r_v0;
        end
        if (en[2]) begin
            r_sec2 <= r_sec1;
            r_v2   <= r_v1;
            r_aq2  <= n_aq;
            r_at2  <= n_at;
            r_ap2  <= n_ap;
        end
        if (en[3]) begin
            r_r3 <= n_r;
            r_g3 <= n_g;
            r_b3 <= n_b;
        end
        if (en[4]) begin
            r_rsp.red   <= chan8(r_r3);
            r_rsp.green <= chan8(r_g3);
            r_rsp.blue  <= chan8(r_b3);
        end
    end

    `HSV_ASSERT_IMP(a_full_when_blocked, !o_ready, r_vld == '1, "input blocked with a free stage")
    `HSV_ASSERT_IMP(a_sector_range, r_vld[0], r_sec0 <= SEC_5, "sector out of range")
    `HSV_ASSERT_IMP(a_rem_range, r_vld[0], r_rem0 <= 12'd3840, "remainder above one sector")
    `HSV_ASSERT_IMP(a_frac_range, r_vld[1], r_f1 <= 9'd256, "fraction above 1.0")
    `HSV_ASSERT_NXT(a_advance, r_vld[0] && en[1], r_vld[1], "request lost between stages")

endmodule

`default_nettype wire

/* tb/tb_hsv_to_rgb_converter_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hsv_to_rgb_converter_unit
// Drives HSV requests through the converter with bursty valid and a stalling
// receiver, predicts each RGB response in fixed point and compares in order.
// ----------------------------------------------------------------------------

module tb_hsv_to_rgb_converter_unit;
    import hsv2rgb_pkg::*;

    localparam int  RANDOM_REQUESTS = 900;
    localparam int  DRAIN_CYCLES    = 20;
    localparam time RUN_LIMIT       = 5_000_000;

    // receiver stall patterns
    localparam logic [1:0] RX_ALWAYS = 2'd0;
    localparam logic [1:0] RX_LIGHT  = 2'd1;
    localparam logic [1:0] RX_HEAVY  = 2'd2;
    localparam logic [1:0] RX_CYCLIC = 2'd3;

    logic     i_clk   = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     i_valid = 1'b0;
    logic     i_ready = 1'b0;
    t_hsv_req i_req   = '0;
    logic     o_ready;
    logic     o_valid;
    t_rgb_rsp o_rsp;

    t_rgb_rsp   rgb_expected[$];
    int         err_count = 0;
    logic [1:0] rx_mode   = RX_ALWAYS;
    int         rx_left   = 0;
    logic [7:0] rx_phase  = '0;

    hsv_to_rgb_converter_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_req   (i_req),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_rsp   (o_rsp)
    );

    always #10 i_clk = ~i_clk;

    function automatic logic [7:0] scale_channel(input longint x);
        longint scaled;
        if (x <= 0) begin
            return 8'd0;
        end
        scaled = (x * 255) >>> 24;
        return (scaled > 255) ? 8'd255 : 8'(scaled);
    endfunction

    function automatic t_rgb_rsp hsv_to_rgb(input t_hsv_req r);
        longint   hue;
        longint   sat;
        longint   val;
        longint   rem;
        longint   frac;
        longint   cv, p, q, t;
        longint   red, green, blue;
        t_sector  sec;
        t_rgb_rsp rgb;
        hue = longint'(r.hue);
        sat = longint'(r.saturation);
        val = longint'(r.brightness);
        if (hue > longint'(HUE_FULL)) begin
            hue = longint'(HUE_FULL);
        end
        // exactly 360 stays in the last sector with a full fraction
        if (hue / longint'(HUE_SECTOR) >= 6) begin
            sec = SEC_5;
        end else begin
            sec = t_sector'(hue / longint'(HUE_SECTOR));
        end
        rem  = hue - longint'(sec) * longint'(HUE_SECTOR);
        frac = (rem * 256) / longint'(HUE_SECTOR);
        cv = val * 65536;
        p  = val * (256 - sat) * 256;
        q  = val * (65536 - frac * sat);
        t  = val * (65536 - (256 - frac) * sat);
        case (sec)
            SEC_0: begin
                red = cv; green = t;  blue = p;
            end
            SEC_1: begin
                red = q;  green = cv; blue = p;
            end
            SEC_2: begin
                red = p;  green = cv; blue = t;
            end
            SEC_3: begin
                red = p;  green = q;  blue = cv;
            end
            SEC_4: begin
                red = t;  green = p;  blue = cv;
            end
            default: begin
                red = cv; green = p;  blue = q;
            end
        endcase
        rgb.red   = scale_channel(red);
        rgb.green = scale_channel(green);
        rgb.blue  = scale_channel(blue);
        return rgb;
    endfunction

    task automatic report_mismatch(input string what, input int exp_v, input int got_v);
        $display("%0t mismatch %s: expected %0d got %0d", $time, what, exp_v, got_v);
        err_count++;
    endtask

    // Pop on response before pushing on request, so a stray response never
    // consumes the expectation of the request accepted in the same cycle.
    always @(posedge i_clk) begin
        t_rgb_rsp want;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (rgb_expected.size() == 0) begin
                    report_mismatch("unexpected response", 0, 1);
                end else begin
                    want = rgb_expected.pop_front();
                    if (o_rsp.red !== want.red)
                        report_mismatch("red", want.red, o_rsp.red);
                    if (o_rsp.green !== want.green)
                        report_mismatch("green", want.green, o_rsp.green);
                    if (o_rsp.blue !== want.blue)
                        report_mismatch("blue", want.blue, o_rsp.blue);
                end
            end
            if (i_valid && o_ready) begin
                rgb_expected.push_back(hsv_to_rgb(i_req));
            end
        end
    end

    // receiver: pick a new stall pattern whenever the rx_left countdown runs out
    always @(posedge i_clk) begin
        rx_phase <= rx_phase + 8'd1;
        if (rx_left == 0) begin
            rx_mode <= 2'($urandom_range(0, 3));
            rx_left <= $urandom_range(16, 96);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            RX_ALWAYS: i_ready <= 1'b1;
            RX_LIGHT:  i_ready <= ($urandom_range(0, 3) != 0);
            RX_HEAVY:  i_ready <= ($urandom_range(0, 9) < 3);
            default:   i_ready <= (rx_phase[2:0] < 3'd5);
        endcase
    end

    // Called at a rising edge; returns at the edge that accepts the request.
    task automatic send_hsv(input logic [14:0] hue, input logic [8:0] sat,
                            input logic [8:0] val);
        t_hsv_req r;
        r.hue        = hue;
        r.saturation = sat;
        r.brightness = val;
        i_valid <= 1'b1;
        i_req   <= r;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic hold_idle(input int cycles);
        i_valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic test_sector_edges();
        send_hsv(15'd0,     9'd256, 9'd256);
        send_hsv(15'd3839,  9'd256, 9'd256);
        send_hsv(15'd3840,  9'd256, 9'd256);
        send_hsv(15'd7679,  9'd200, 9'd256);
        send_hsv(15'd7680,  9'd200, 9'd180);
        send_hsv(15'd11520, 9'd128, 9'd256);
        send_hsv(15'd15360, 9'd256, 9'd100);
        send_hsv(15'd19200, 9'd256, 9'd256);
        send_hsv(15'd23039, 9'd256, 9'd256);
        send_hsv(15'd23040, 9'd256, 9'd256);
        send_hsv(15'd23041, 9'd256, 9'd256);
        send_hsv(15'd32767, 9'd77,  9'd200);
        hold_idle(3);
    endtask

    task automatic test_field_extremes();
        send_hsv(15'd5000,  9'd0,   9'd256);
        send_hsv(15'd5000,  9'd511, 9'd256);
        send_hsv(15'd17000, 9'd511, 9'd511);
        send_hsv(15'd1000,  9'd0,   9'd511);
        send_hsv(15'd9000,  9'd300, 9'd0);
        send_hsv(15'd13000, 9'd256, 9'd511);
        send_hsv(15'd21000, 9'd511, 9'd1);
        send_hsv(15'd32767, 9'd511, 9'd511);
        send_hsv(15'd0,     9'd0,   9'd0);
        send_hsv(15'd1920,  9'd128, 9'd128);
        hold_idle(3);
    endtask

    task automatic send_random_hsv();
        logic [14:0] hue;
        logic [8:0]  sat;
        logic [8:0]  val;
        case ($urandom_range(0, 7))
            0:       hue = 15'($urandom_range(0, 6) * 3840 + $urandom_range(0, 4) - 2);
            1:       hue = 15'($urandom_range(23040, 32767));
            default: hue = 15'($urandom_range(0, 23040));
        endcase
        sat = ($urandom_range(0, 3) == 0) ? 9'($urandom_range(0, 511))
                                          : 9'($urandom_range(0, 256));
        val = ($urandom_range(0, 3) == 0) ? 9'($urandom_range(0, 511))
                                          : 9'($urandom_range(0, 256));
        send_hsv(hue, sat, val);
    endtask

    task automatic test_random_stream();
        int sent;
        int burst;
        sent = 0;
        while (sent < RANDOM_REQUESTS) begin
            burst = ($urandom_range(0, 15) == 0) ? 80 : $urandom_range(1, 12);
            repeat (burst) begin
                send_random_hsv();
                sent++;
            end
            hold_idle($urandom_range(1, 5));
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_sector_edges();
        test_field_extremes();
        test_random_stream();
        i_valid <= 1'b0;
        while (rgb_expected.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("tb_hsv_to_rgb_converter_unit: clean");
        end else begin
            $display("tb_hsv_to_rgb_converter_unit: errors");
        end
        $finish;
    end

    initial begin
        #RUN_LIMIT;
        $display("timeout with %0d responses outstanding", rgb_expected.size());
        $display("tb_hsv_to_rgb_converter_unit: errors");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/hsv2rgb_pkg.sv
rtl/hsv_to_rgb_converter_unit.sv
tb/tb_hsv_to_rgb_converter_unit.sv
